[src/psrm_pkg.sv]
`default_nettype none
package psrm_pkg;

	// item kinds
	localparam logic [1:0] MODE_SAMPLE     = 2'd0;
	localparam logic [1:0] MODE_CLEAR_STAT = 2'd1;
	localparam logic [1:0] MODE_CLEAR_FILL = 2'd2;

	// division jobs, run in this order
	localparam logic [1:0] DIV_VOLT   = 2'd0;
	localparam logic [1:0] DIV_CURR   = 2'd1;
	localparam logic [1:0] DIV_COS    = 2'd2;
	localparam logic [1:0] DIV_RECENT = 2'd3;

	localparam int VOLT_W = 10;
	localparam int CURR_W = 16;
	localparam int COS_W  = 11;
	localparam int WIN_W  = 6;
	localparam logic [WIN_W-1:0] WIN_RESET = 6'd16;

	typedef struct packed {
		logic       capture;
		logic       update;
		logic       snap;
		logic       div_start;
		logic [1:0] div_sel;
		logic       load_out;
	} psrm_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic div_done;
		logic out_busy;
	} psrm_sts_t;

endpackage
`default_nettype wire

[src/psrm_div.sv]
`default_nettype none
module psrm_div #(
	parameter int NW = 22,
	parameter int DW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [NW-1:0] quot,
	output logic               done
);
	localparam int SW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quot_q;
	logic [SW-1:0] steps_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quot_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= busy_q && (steps_q == SW'(1));
			if (start) begin
				busy_q  <= 1'b1;
				steps_q <= SW'(NW);
			end else if (busy_q) begin
				steps_q <= steps_q - SW'(1);
				if (steps_q == SW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// one quotient bit a cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			den_q  <= den;
			quot_q <= num;
		end else if (busy_q) begin
			rem_q  <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quot_q <= {quot_q[NW-2:0], fits};
		end
	end

	assign quot = quot_q;
	assign done = done_q;
endmodule
`default_nettype wire

[src/psrm_ctrl.sv]
`default_nettype none
module psrm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire psrm_pkg::psrm_sts_t  sts,
	output psrm_pkg::psrm_cmd_t       cmd
);
	import psrm_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UPD   = 3'd1;
	localparam logic [2:0] S_SNAP  = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_DWAIT = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] job_q;
	logic       accept;

	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.div_sel   = job_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_d     = S_UPD;
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_SNAP;
			end
			S_SNAP: begin
				cmd.snap = 1'b1;
				state_d  = S_WALK;
			end
			S_WALK: begin
				if (sts.walk_done)
					state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.div_done)
					state_d = (job_q == DIV_RECENT) ? S_OUT : S_DIV;
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= DIV_VOLT;
		end else begin
			state_q <= state_d;
			if (state_q == S_SNAP)
				job_q <= DIV_VOLT;
			else if (state_q == S_DWAIT && sts.div_done && job_q != DIV_RECENT)
				job_q <= job_q + 2'd1;
		end
	end

	a_accept_goes_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_UPD)
		else $error("accepted item did not start an update");
	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.out_busy)
		else $error("result loaded over a waiting result");
	a_out_after_recent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> job_q == DIV_RECENT)
		else $error("result stage reached before all divisions");
	a_div_in_dwait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == S_DWAIT)
		else $error("division start without wait");
endmodule
`default_nettype wire

[src/psrm_dp.sv]
`default_nettype none
module psrm_dp #(
	parameter int HISTORY_DEPTH = 32,
	parameter int PHASES        = 3,
	parameter int CW            = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire psrm_pkg::psrm_cmd_t           cmd,
	output psrm_pkg::psrm_sts_t                sts,
	input  wire logic                          cfg_we,
	input  wire logic [psrm_pkg::WIN_W-1:0]    cfg_wdata,
	input  wire logic [1:0]                    mode,
	input  wire logic [1:0]                    phase,
	input  wire logic [psrm_pkg::VOLT_W-1:0]   volt,
	input  wire logic [psrm_pkg::CURR_W-1:0]   curr,
	input  wire logic signed [psrm_pkg::COS_W-1:0] cos_phi,
	input  wire logic                          phase_running,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [CW-1:0]                      sample_count,
	output logic [psrm_pkg::VOLT_W-1:0]        volt_low,
	output logic [psrm_pkg::VOLT_W-1:0]        volt_high,
	output logic [psrm_pkg::VOLT_W-1:0]        volt_mean,
	output logic [psrm_pkg::CURR_W-1:0]        curr_low,
	output logic [psrm_pkg::CURR_W-1:0]        curr_high,
	output logic [psrm_pkg::CURR_W-1:0]        curr_mean,
	output logic signed [psrm_pkg::COS_W-1:0]  cos_low,
	output logic signed [psrm_pkg::COS_W-1:0]  cos_high,
	output logic signed [psrm_pkg::COS_W-1:0]  cos_mean,
	output logic [psrm_pkg::VOLT_W-1:0]        recent_mean
);
	import psrm_pkg::*;

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int AW    = $clog2(PHASES * HISTORY_DEPTH);
	localparam int PIW   = (PHASES > 1) ? $clog2(PHASES) : 1;
	localparam int VSW   = VOLT_W + CW;
	localparam int CSW   = CURR_W + CW;
	localparam int KSW   = COS_W + CW;
	localparam int NW    = CSW;
	localparam logic [CW-1:0]    DEPTH  = CW'(HISTORY_DEPTH);
	localparam logic [PTR_W-1:0] LAST   = PTR_W'(HISTORY_DEPTH - 1);

	// captured item
	logic [1:0]              mode_q;
	logic [PIW-1:0]          pi_q;
	logic                    pok_q;
	logic [VOLT_W-1:0]       volt_q;
	logic [CURR_W-1:0]       curr_q;
	logic signed [COS_W-1:0] cos_q;
	logic                    run_q;
	logic [WIN_W-1:0]        win_q;

	// per-phase statistics
	logic [CW-1:0]           cnt_q  [PHASES];
	logic [CW-1:0]           fill_q [PHASES];
	logic [PTR_W-1:0]        wp_q   [PHASES];
	logic [VOLT_W-1:0]       vlo_q  [PHASES];
	logic [VOLT_W-1:0]       vhi_q  [PHASES];
	logic [VSW-1:0]          vsum_q [PHASES];
	logic [CURR_W-1:0]       clo_q  [PHASES];
	logic [CURR_W-1:0]       chi_q  [PHASES];
	logic [CSW-1:0]          csum_q [PHASES];
	logic signed [COS_W-1:0] klo_q  [PHASES];
	logic signed [COS_W-1:0] khi_q  [PHASES];
	logic signed [KSW-1:0]   ksum_q [PHASES];

	logic [VOLT_W-1:0] hist_mem [PHASES * HISTORY_DEPTH];
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [AW-1:0]     mem_raddr;
	logic [VOLT_W-1:0] rd_s1;
	logic              pend_s1;

	// snapshot for reporting
	logic                    sn_ok_q;
	logic [CW-1:0]           sn_cnt_q;
	logic [CW-1:0]           sn_rcnt_q;
	logic [VOLT_W-1:0]       sn_vlo_q, sn_vhi_q;
	logic [VSW-1:0]          sn_vsum_q;
	logic [CURR_W-1:0]       sn_clo_q, sn_chi_q;
	logic [CSW-1:0]          sn_csum_q;
	logic signed [COS_W-1:0] sn_klo_q, sn_khi_q;
	logic signed [KSW-1:0]   sn_ksum_q;

	logic              walk_q;
	logic [CW-1:0]     left_q;
	logic [PTR_W-1:0]  rp_q;
	logic [VSW-1:0]    rsum_q;
	logic              walk_done;

	logic [VOLT_W-1:0] res_v_q;
	logic [CURR_W-1:0] res_c_q;
	logic [COS_W-1:0]  res_k_q;
	logic [VOLT_W-1:0] res_r_q;

	logic [NW-1:0]     div_num;
	logic [CW-1:0]     div_den;
	logic [NW-1:0]     div_quot;
	logic              div_done;
	logic [KSW-1:0]    kmag;
	logic [COS_W-1:0]  kq;
	logic              out_valid_q;
	logic              do_sample;
	logic              first;
	logic [CW-1:0]     rcnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= WIN_RESET;
		else if (cfg_we)
			win_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			pi_q   <= PIW'(phase);
			pok_q  <= int'(phase) < PHASES;
			volt_q <= volt;
			curr_q <= curr;
			cos_q  <= cos_phi;
			run_q  <= phase_running;
		end
	end

	assign do_sample = cmd.update && pok_q && mode_q == MODE_SAMPLE && !run_q;
	assign first     = cnt_q[pi_q] == '0 || cnt_q[pi_q] >= DEPTH;
	assign mem_we    = do_sample;
	assign mem_waddr = AW'(pi_q) * AW'(HISTORY_DEPTH) + AW'(wp_q[pi_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PHASES; i++) begin
				cnt_q[i]  <= '0;
				fill_q[i] <= '0;
				wp_q[i]   <= '0;
			end
		end else if (cmd.update && pok_q) begin
			if (mode_q == MODE_CLEAR_STAT) begin
				for (int i = 0; i < PHASES; i++)
					cnt_q[i] <= '0;
			end else if (mode_q == MODE_CLEAR_FILL) begin
				fill_q[pi_q] <= '0;
			end else if (do_sample) begin
				cnt_q[pi_q] <= first ? CW'(1) : cnt_q[pi_q] + CW'(1);
				if (fill_q[pi_q] < DEPTH)
					fill_q[pi_q] <= fill_q[pi_q] + CW'(1);
				wp_q[pi_q] <= (wp_q[pi_q] == LAST) ? '0 : wp_q[pi_q] + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_sample) begin
			if (first) begin
				vlo_q[pi_q]  <= volt_q;
				vhi_q[pi_q]  <= volt_q;
				vsum_q[pi_q] <= VSW'(volt_q);
				clo_q[pi_q]  <= curr_q;
				chi_q[pi_q]  <= curr_q;
				csum_q[pi_q] <= CSW'(curr_q);
				klo_q[pi_q]  <= cos_q;
				khi_q[pi_q]  <= cos_q;
				ksum_q[pi_q] <= KSW'(cos_q);
			end else begin
				if (volt_q < vlo_q[pi_q]) vlo_q[pi_q] <= volt_q;
				if (volt_q > vhi_q[pi_q]) vhi_q[pi_q] <= volt_q;
				vsum_q[pi_q] <= vsum_q[pi_q] + VSW'(volt_q);
				if (curr_q < clo_q[pi_q]) clo_q[pi_q] <= curr_q;
				if (curr_q > chi_q[pi_q]) chi_q[pi_q] <= curr_q;
				csum_q[pi_q] <= csum_q[pi_q] + CSW'(curr_q);
				if (cos_q < klo_q[pi_q]) klo_q[pi_q] <= cos_q;
				if (cos_q > khi_q[pi_q]) khi_q[pi_q] <= cos_q;
				ksum_q[pi_q] <= ksum_q[pi_q] + KSW'(cos_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			hist_mem[mem_waddr] <= volt_q;
	end

	always_ff @(posedge clk) begin
		rd_s1 <= hist_mem[mem_raddr];
	end

	assign rcnt = (int'(win_q) < int'(fill_q[pi_q])) ? CW'(win_q) : fill_q[pi_q];

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			sn_ok_q   <= pok_q;
			sn_cnt_q  <= pok_q ? cnt_q[pi_q] : '0;
			sn_rcnt_q <= pok_q ? rcnt : '0;
			sn_vlo_q  <= vlo_q[pi_q];
			sn_vhi_q  <= vhi_q[pi_q];
			sn_vsum_q <= vsum_q[pi_q];
			sn_clo_q  <= clo_q[pi_q];
			sn_chi_q  <= chi_q[pi_q];
			sn_csum_q <= csum_q[pi_q];
			sn_klo_q  <= klo_q[pi_q];
			sn_khi_q  <= khi_q[pi_q];
			sn_ksum_q <= ksum_q[pi_q];
		end
	end

	// walk back from the newest history entry, one read a cycle
	assign mem_raddr = AW'(pi_q) * AW'(HISTORY_DEPTH) + AW'(rp_q);
	assign walk_done = walk_q && left_q == '0 && !pend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q  <= 1'b0;
			pend_s1 <= 1'b0;
			left_q  <= '0;
		end else begin
			pend_s1 <= walk_q && left_q != '0;
			if (cmd.snap) begin
				walk_q <= 1'b1;
				left_q <= pok_q ? rcnt : '0;
			end else if (walk_done) begin
				walk_q <= 1'b0;
			end else if (walk_q && left_q != '0) begin
				left_q <= left_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			rp_q   <= (wp_q[pi_q] == '0) ? LAST : wp_q[pi_q] - PTR_W'(1);
			rsum_q <= '0;
		end else begin
			if (walk_q && left_q != '0)
				rp_q <= (rp_q == '0) ? LAST : rp_q - PTR_W'(1);
			if (pend_s1)
				rsum_q <= rsum_q + VSW'(rd_s1);
		end
	end

	assign kmag = sn_ksum_q[KSW-1] ? KSW'(-sn_ksum_q) : KSW'(sn_ksum_q);

	always_comb begin
		div_num = '0;
		div_den = sn_cnt_q;
		case (cmd.div_sel)
			DIV_VOLT:   div_num = NW'(sn_vsum_q);
			DIV_CURR:   div_num = sn_csum_q;
			DIV_COS:    div_num = NW'(kmag);
			DIV_RECENT: begin
				div_num = NW'(rsum_q);
				div_den = sn_rcnt_q;
			end
			default:    div_num = '0;
		endcase
	end

	psrm_div #(.NW(NW), .DW(CW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.done   (div_done)
	);

	// truncation toward zero: divide the magnitude, then restore the sign
	assign kq = sn_ksum_q[KSW-1] ? COS_W'(-div_quot[COS_W-1:0]) : div_quot[COS_W-1:0];

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.div_sel)
				DIV_VOLT:   res_v_q <= (div_den == '0) ? '0 : div_quot[VOLT_W-1:0];
				DIV_CURR:   res_c_q <= (div_den == '0) ? '0 : div_quot[CURR_W-1:0];
				DIV_COS:    res_k_q <= (div_den == '0) ? '0 : kq;
				DIV_RECENT: res_r_q <= (div_den == '0) ? '0 : div_quot[VOLT_W-1:0];
				default:    res_v_q <= res_v_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sample_count <= sn_cnt_q;
			volt_low     <= (sn_cnt_q == '0) ? '0 : sn_vlo_q;
			volt_high    <= (sn_cnt_q == '0) ? '0 : sn_vhi_q;
			volt_mean    <= res_v_q;
			curr_low     <= (sn_cnt_q == '0) ? '0 : sn_clo_q;
			curr_high    <= (sn_cnt_q == '0) ? '0 : sn_chi_q;
			curr_mean    <= res_c_q;
			cos_low      <= (sn_cnt_q == '0) ? '0 : sn_klo_q;
			cos_high     <= (sn_cnt_q == '0) ? '0 : sn_khi_q;
			cos_mean     <= res_k_q;
			recent_mean  <= sn_ok_q ? res_r_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.walk_done = walk_done;
	assign sts.div_done  = div_done;
	assign sts.out_busy  = out_valid_q && out_stall;

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[0] <= DEPTH)
		else $error("history fill beyond depth");
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= DEPTH)
		else $error("sample count beyond depth");
	a_walk_within_window: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q |-> left_q <= sn_rcnt_q)
		else $error("history walk longer than window");
endmodule
`default_nettype wire

[src/phase_stats_and_recent_mean.sv]
`default_nettype none
// channel   handshake             payload
// in        in_valid / in_stall   mode, phase, volt, curr, cos_phi, phase_running
// out       out_valid / out_stall sample_count, volt_*, curr_*, cos_*, recent_mean
// cfg       cfg_we                cfg_wdata (window_points)
//
// one item at a time: accept, update, snapshot, then a history walk of
// min(window_points, fill) entries, one history read a cycle, then four divisions in one
// shared radix-2 divider, then a load of the output register.
// a finished result waits in the output register while the next item is taken.
// reset clears counts, fill, pointers, window (16) and the output valid.
module phase_stats_and_recent_mean #(
	parameter int HISTORY_DEPTH = 32,
	parameter int PHASES        = 3,
	localparam int CW           = $clog2(HISTORY_DEPTH + 1)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [psrm_pkg::WIN_W-1:0]         cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [1:0]                         mode,
	input  wire logic [1:0]                         phase,
	input  wire logic [psrm_pkg::VOLT_W-1:0]        volt,
	input  wire logic [psrm_pkg::CURR_W-1:0]        curr,
	input  wire logic signed [psrm_pkg::COS_W-1:0]  cos_phi,
	input  wire logic                               phase_running,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [CW-1:0]                           sample_count,
	output logic [psrm_pkg::VOLT_W-1:0]             volt_low,
	output logic [psrm_pkg::VOLT_W-1:0]             volt_high,
	output logic [psrm_pkg::VOLT_W-1:0]             volt_mean,
	output logic [psrm_pkg::CURR_W-1:0]             curr_low,
	output logic [psrm_pkg::CURR_W-1:0]             curr_high,
	output logic [psrm_pkg::CURR_W-1:0]             curr_mean,
	output logic signed [psrm_pkg::COS_W-1:0]       cos_low,
	output logic signed [psrm_pkg::COS_W-1:0]       cos_high,
	output logic signed [psrm_pkg::COS_W-1:0]       cos_mean,
	output logic [psrm_pkg::VOLT_W-1:0]             recent_mean
);
	import psrm_pkg::*;

	psrm_cmd_t cmd;
	psrm_sts_t sts;

	psrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	psrm_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.PHASES        (PHASES),
		.CW            (CW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mode          (mode),
		.phase         (phase),
		.volt          (volt),
		.curr          (curr),
		.cos_phi       (cos_phi),
		.phase_running (phase_running),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_count  (sample_count),
		.volt_low      (volt_low),
		.volt_high     (volt_high),
		.volt_mean     (volt_mean),
		.curr_low      (curr_low),
		.curr_high     (curr_high),
		.curr_mean     (curr_mean),
		.cos_low       (cos_low),
		.cos_high      (cos_high),
		.cos_mean      (cos_mean),
		.recent_mean   (recent_mean)
	);
endmodule
`default_nettype wire
